[rtl/tswq_pkg.sv]
// tswq_pkg: shared types and constants of the task sleep/wakeup queue
// used by every module of the block but tswq_ram; depends on nothing
`default_nettype none

package tswq_pkg;

    localparam int TASK_ID_W     = 4;
    localparam int TICK_W        = 64;
    localparam int MAX_TASKS_DEF = 16;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((TASK_ID_W + TICK_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TASK_ID_W + 7) / 8) * 8;

    // item kinds carried in s_tuser
    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // one classified command handed from front to back
    typedef struct packed {
        op_t                   op;
        logic [TASK_ID_W-1:0]  task_id;
        logic [TICK_W-1:0]     delay;
    } cmd_t;

    // one entry of the sleep queue
    typedef struct packed {
        logic [TASK_ID_W-1:0]  task_id;
        logic [TICK_W-1:0]     wakeup;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/task_sleep_wakeup_queue_top.sv]
// task_sleep_wakeup_queue_top: top level of the task sleep/wakeup queue
// depends on tswq_pkg, tswq_front, tswq_back, tswq_ram
//
// Usage:
//   Input words arrive on the s_ stream. s_tuser selects the kind: sleep puts
//   task_id to sleep for delay_ticks ticks, tick advances the 64-bit tick
//   counter and wakes every queued task that is due, in queue order.
//   Each woken task leaves as one word on the m_ stream; m_tlast marks the
//   final word of a tick. Sleep words and ticks with nothing due give no word.
//   A sleep for an already queued task moves it to the tail with its new
//   wakeup tick; a sleep for a new task while the queue is full is dropped.
// Operation:
//   A two-word command queue decouples the input from the engine, which runs
//   one command at a time: setup, one ram read per entry of the queue (at most
//   MAX_TASKS entries), the compacting write behind it, and the tail append or
//   final word.
// Reset and stall:
//   aresetn clears the tick counter and empties the queue; no clearing pass.
//   While m_tready is low the engine holds at the next woken task, and the
//   command queue fills and then lowers s_tready.
`default_nettype none

module task_sleep_wakeup_queue_top
    import tswq_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // task_id[3:0], delay_ticks[67:4], zero pad
    input  wire logic                 s_tuser,   // op
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // woken_task[3:0], zero pad
    output logic                      m_tlast
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // accept and classify incoming words
    tswq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // execute commands on the sleep queue
    tswq_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/tswq_ram.sv]
// tswq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tswq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/tswq_front.sv]
// tswq_front: accepts stream words, classifies them into commands and buffers
// them in a two-entry queue; depends on tswq_pkg
`default_nettype none

module tswq_front
    import tswq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    output logic                      cmd_valid,
    input  wire logic                 cmd_ready,
    output cmd_t                      cmd
);

    cmd_t        slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    cmd_t        in_cmd;

    // unpack the incoming word
    always_comb begin
        in_cmd.op      = op_t'(s_tuser);
        in_cmd.task_id = s_tdata[TASK_ID_W-1:0];
        in_cmd.delay   = s_tdata[TASK_ID_W +: TICK_W];
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/tswq_back.sv]
// tswq_back: executes sleep and tick commands on the queue ram, compacting the
// queue in one pass and driving the result register; depends on tswq_pkg, tswq_ram
`default_nettype none

module tswq_back
    import tswq_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cmd_valid,
    output logic                      cmd_ready,
    input  wire cmd_t                 cmd,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [CW-1:0]         len_reg, len_next;
    logic [CW-1:0]         rd_idx_reg, rd_idx_next;
    logic [CW-1:0]         wr_idx_reg, wr_idx_next;
    logic                  eval_valid_reg, eval_valid_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [TASK_ID_W-1:0]  pend_id_reg, pend_id_next;
    logic                  m_valid_reg, m_valid_next;
    logic [TASK_ID_W-1:0]  m_id_reg, m_id_next;
    logic                  m_last_reg, m_last_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    entry_t                ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    entry_t                rd_entry;
    logic                  is_tick;
    logic                  due;
    logic                  keep;
    logic                  out_free;
    logic                  stall;

    tswq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // classify the entry coming out of the ram
    assign rd_entry = entry_t'(ram_rdata);
    assign is_tick  = (cmd_reg.op == OP_TICK);
    assign due      = (rd_entry.wakeup <= tick_reg);
    assign keep     = is_tick ? !due : (rd_entry.task_id != cmd_reg.task_id);
    assign out_free = !m_valid_reg || m_tready;
    // a second woken task needs the result register to take the held one
    assign stall    = eval_valid_reg && !keep && is_tick && pend_valid_reg && !out_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_TDATA_W'(m_id_reg);
    assign m_tlast   = m_last_reg;

    // next-state logic of the execution engine
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        tick_next       = tick_reg;
        len_next        = len_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        eval_valid_next = eval_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_id_next       = m_id_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_idx_reg[AW-1:0];
        ram_wdata       = rd_entry;
        ram_re          = 1'b0;
        ram_raddr       = rd_idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next        = cmd;
                    if (cmd.op == OP_TICK) begin
                        tick_next = tick_reg + TICK_W'(1);
                    end
                    rd_idx_next     = '0;
                    wr_idx_next     = '0;
                    eval_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (!stall) begin
                    // retire the entry last read from the ram
                    if (eval_valid_reg) begin
                        if (keep) begin
                            ram_we      = 1'b1;
                            wr_idx_next = wr_idx_reg + CW'(1);
                        end else if (is_tick) begin
                            if (pend_valid_reg) begin
                                m_valid_next = 1'b1;
                                m_id_next    = pend_id_reg;
                                m_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_id_next    = rd_entry.task_id;
                        end
                    end
                    // read the next entry
                    if (rd_idx_reg < len_reg) begin
                        ram_re          = 1'b1;
                        rd_idx_next     = rd_idx_reg + CW'(1);
                        eval_valid_next = 1'b1;
                    end else begin
                        eval_valid_next = 1'b0;
                        if (!eval_valid_reg) begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_FINISH: begin
                if (!is_tick) begin
                    // append at the tail unless the queue is full
                    if (wr_idx_reg < CW'(MAX_TASKS)) begin
                        ram_we            = 1'b1;
                        ram_wdata.task_id = cmd_reg.task_id;
                        ram_wdata.wakeup  = tick_reg + cmd_reg.delay;
                        len_next          = wr_idx_reg + CW'(1);
                    end else begin
                        len_next = wr_idx_reg;
                    end
                    state_next = ST_IDLE;
                end else begin
                    len_next = wr_idx_reg;
                    if (!pend_valid_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_id_next       = pend_id_reg;
                        m_last_next     = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= '0;
            tick_reg       <= '0;
            len_reg        <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            eval_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            m_valid_reg    <= 1'b0;
            m_id_reg       <= '0;
            m_last_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            tick_reg       <= tick_next;
            len_reg        <= len_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            pend_id_reg    <= pend_id_next;
            m_valid_reg    <= m_valid_next;
            m_id_reg       <= m_id_next;
            m_last_reg     <= m_last_next;
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_task_sleep_wakeup_queue_top.sv]
// tb_task_sleep_wakeup_queue_top: self-checking bench for the task sleep/wakeup queue
// drives sleep and tick words, mirrors the queue and tick counter, checks woken ids
// depends on tswq_pkg and task_sleep_wakeup_queue_top
`timescale 1ns / 100ps

module tb_task_sleep_wakeup_queue_top;
    import tswq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_PCT    = 28;

    // one input word waiting to be sent
    typedef struct {
        op_t         op;
        logic [3:0]  task_id;
        logic [63:0] delay;
        bit          drain;   // hold off until every woken id has come back
        bit          calm;    // no idling on either side while this word is out
    } sleep_word_t;

    // one woken id the block should return
    typedef struct {
        logic [3:0] task_id;
        logic       last;
    } wake_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // task_id[3:0], delay_ticks[67:4], zero pad
    logic                 s_tuser  = 1'b0; // op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // woken_task[3:0], zero pad
    logic                 m_tlast;

    sleep_word_t pending_words[$];
    wake_t       due_wakes[$];
    sleep_word_t cur_word;
    bit          calm_now = 1'b0;
    int          err_cnt  = 0;
    int          stall_cnt = 0;

    // mirror of the block state
    logic [63:0] now_tick;
    logic [3:0]  sleep_ids[QUEUE_DEPTH];
    logic [63:0] sleep_due[QUEUE_DEPTH];
    int          sleep_len;

    task_sleep_wakeup_queue_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // remove one queue entry, later entries close up
    task automatic drop_sleeper(input int pos);
        for (int k = pos; k + 1 < sleep_len; k++) begin
            sleep_ids[k] = sleep_ids[k + 1];
            sleep_due[k] = sleep_due[k + 1];
        end
        sleep_len--;
    endtask

    // apply one accepted word to the mirror and queue up the ids it wakes
    task automatic apply_word_to_queue(input sleep_word_t w);
        int    k;
        int    woken;
        wake_t wk;
        k = 0;
        woken = 0;
        if (w.op == OP_SLEEP) begin
            // a task already asleep moves to the tail with its new wakeup tick
            for (int j = 0; j < sleep_len; j++) begin
                if (sleep_ids[j] == w.task_id) begin
                    drop_sleeper(j);
                    break;
                end
            end
            if (sleep_len < QUEUE_DEPTH) begin
                sleep_ids[sleep_len] = w.task_id;
                sleep_due[sleep_len] = now_tick + w.delay;
                sleep_len++;
            end
        end else begin
            now_tick = now_tick + 64'd1;
            while (k < sleep_len) begin
                if (sleep_due[k] <= now_tick) begin
                    wk.task_id = sleep_ids[k];
                    wk.last    = 1'b0;
                    due_wakes.push_back(wk);
                    woken++;
                    drop_sleeper(k);
                end else begin
                    k++;
                end
            end
            if (woken > 0)
                due_wakes[due_wakes.size() - 1].last = 1'b1;
        end
    endtask

    task automatic push_word(input op_t op, input logic [3:0] id, input logic [63:0] dly,
                             input bit drain, input bit calm);
        sleep_word_t w;
        w.op      = op;
        w.task_id = id;
        w.delay   = dly;
        w.drain   = drain;
        w.calm    = calm;
        pending_words.push_back(w);
    endtask

    // driver: present the next word, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                apply_word_to_queue(cur_word);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0
                        && !(pending_words[0].drain && due_wakes.size() > 0)
                        && (pending_words[0].calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_word = pending_words.pop_front();
                    calm_now = cur_word.calm;
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cur_word.delay, cur_word.task_id});
                    s_tuser  <= cur_word.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and check of each woken word
    always @(posedge aclk) begin
        wake_t exp_wake;
        m_tready <= calm_now || ($urandom_range(0, 99) >= IDLE_PCT);
        if (aresetn && m_tvalid && m_tready) begin
            if (due_wakes.size() == 0) begin
                $error("woken_task: expected none, actual %0d", m_tdata[3:0]);
                err_cnt++;
            end else begin
                exp_wake = due_wakes.pop_front();
                if (m_tdata[3:0] !== exp_wake.task_id) begin
                    $error("woken_task: expected %0d, actual %0d",
                           exp_wake.task_id, m_tdata[3:0]);
                    err_cnt++;
                end
                if (m_tlast !== exp_wake.last) begin
                    $error("last: expected %0b, actual %0b", exp_wake.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int          r;
        logic [3:0]  id;
        logic [63:0] dly;
        bit          drain;
        bit          calm;
        now_tick  = '0;
        sleep_len = 0;

        // tick with nothing asleep
        push_word(OP_TICK, 4'd0, 64'd0, 1'b0, 1'b0);
        // fill the queue: delay zero and all-ones (wraps, due at once), task 6 not due
        for (int t = 0; t < QUEUE_DEPTH; t++) begin
            if (t == 6)
                dly = 64'd3;
            else if (t % 2 == 0)
                dly = 64'd0;
            else
                dly = '1;
            push_word(OP_SLEEP, 4'(t), dly, 1'b0, 1'b0);
        end
        // re-sleep task 6 on a full queue, moves it to the tail; then all sixteen wake
        push_word(OP_SLEEP, 4'd6, 64'd0, 1'b0, 1'b0);
        push_word(OP_TICK, 4'd0, 64'd0, 1'b1, 1'b0);
        push_word(OP_TICK, 4'd0, 64'd0, 1'b0, 1'b0);
        // far wakeup that never comes due in this run
        push_word(OP_SLEEP, 4'd9, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0);
        push_word(OP_TICK, 4'd0, 64'd0, 1'b0, 1'b0);

        // random mix, mostly short sleeps so that ticks wake plenty
        for (int i = 0; i < 350; i++) begin
            calm  = (i >= 140 && i < 210);
            drain = (i % 100 == 60);
            r     = $urandom_range(0, 99);
            if (r < 36) begin
                push_word(OP_TICK, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                          drain, calm);
            end else begin
                id = 4'($urandom_range(0, 15));
                r  = $urandom_range(0, 99);
                if (r < 72)
                    dly = 64'($urandom_range(0, 6));
                else if (r < 84)
                    dly = 64'd0 - 64'($urandom_range(1, 8));
                else
                    dly = {$urandom, $urandom};
                push_word(OP_SLEEP, id, dly, drain, calm);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (due_wakes.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
rtl/tswq_pkg.sv
rtl/tswq_ram.sv
rtl/tswq_front.sv
rtl/tswq_back.sv
rtl/task_sleep_wakeup_queue_top.sv
tb/sv/tb_task_sleep_wakeup_queue_top.sv
